[rtl/plin_pkg.sv]
// plin_pkg: sizes, command codes and controller/datapath structs of the
// piecewise linear interpolator. No dependencies.
package plin_pkg;

	// table and field sizes
	localparam int DEPTH     = 32;
	localparam int AW        = 5;
	localparam int W         = 32;
	localparam int CNT_CFG_W = 6;
	localparam int TOL_W     = 16;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	// arithmetic sizes
	localparam int DW     = W + 1;
	localparam int PW     = 2 * DW;
	localparam int QSAT_W = 41;
	localparam int SUM_W  = QSAT_W + 1;
	localparam int STEP_W = $clog2(PW);

	// iteration counts of the serial units
	localparam int MUL_STEPS = DW;
	localparam int DIV_STEPS = PW;

	// register indexes by paddr[2]
	localparam logic REG_POINT_COUNT = 1'b0;
	localparam logic REG_HIT_TOL     = 1'b1;

	// input kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// status codes
	localparam logic STAT_OK    = 1'b0;
	localparam logic STAT_ORDER = 1'b1;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_QUERY,
		OP_CAP0,
		OP_CAPL,
		OP_EVAL,
		OP_CAPA,
		OP_CAPB,
		OP_MUL,
		OP_DIV,
		OP_FIN
	} op_t;

	typedef struct packed {
		op_t           op;
		logic [AW-1:0] addr;
		logic          first;
	} cmd_t;

	typedef struct packed {
		logic order_err;
		logic hit;
		logic below;
		logic sp_lo;
		logic sp_hi;
	} stat_t;

endpackage

[rtl/plin_dp.sv]
// plin_dp: breakpoint memories, scan compare logic, serial multiplier,
// restoring divider and saturating output. Depends on plin_pkg.
module plin_dp (
	input  logic                          clk,
	input  plin_pkg::cmd_t                cmd,
	input  logic [plin_pkg::AW-1:0]       point_index,
	input  logic signed [plin_pkg::W-1:0] point_x,
	input  logic signed [plin_pkg::W-1:0] point_y,
	input  logic signed [plin_pkg::W-1:0] setpoint,
	input  logic [plin_pkg::TOL_W-1:0]    hit_tolerance,
	output plin_pkg::stat_t               stat,
	output logic signed [plin_pkg::W-1:0] value,
	output logic                          status
);

	logic [plin_pkg::W-1:0] mem_x [plin_pkg::DEPTH];
	logic [plin_pkg::W-1:0] mem_y [plin_pkg::DEPTH];

	logic signed [plin_pkg::W-1:0] rdx_q, rdy_q;
	logic signed [plin_pkg::W-1:0] sp_q, x0_q, y0_q, prev_q, xa_q, ya_q;
	logic hit0_q, inrange_q, sp_lo_q, sp_hi_q, neg_q;
	logic [plin_pkg::DW-1:0] ma_q, mb_q, den_q;
	logic [plin_pkg::DW:0]   rem_q;
	logic [plin_pkg::PW-1:0] acc_q;
	logic signed [plin_pkg::W-1:0] value_q;
	logic status_q;

	// |a - b| < tol
	function automatic logic near(input logic signed [plin_pkg::W-1:0] a,
			input logic signed [plin_pkg::W-1:0] b, input logic [plin_pkg::TOL_W-1:0] tol);
		logic signed [plin_pkg::DW-1:0] d;
		logic [plin_pkg::DW-1:0] m;
		begin
			d = {a[plin_pkg::W-1], a} - {b[plin_pkg::W-1], b};
			m = d[plin_pkg::DW-1] ? (~d + plin_pkg::DW'(1)) : d;
			return m < plin_pkg::DW'(tol);
		end
	endfunction

	// table write and registered read
	always_ff @(posedge clk) begin
		if (cmd.op == plin_pkg::OP_LOAD) begin
			mem_x[point_index] <= point_x;
			mem_y[point_index] <= point_y;
		end
		rdx_q <= mem_x[cmd.addr];
		rdy_q <= mem_y[cmd.addr];
	end

	// scan compares
	logic hit_lo;
	always_comb begin
		hit_lo         = cmd.first && hit0_q;
		stat.order_err = prev_q >= rdx_q;
		stat.hit       = inrange_q && (hit_lo || near(sp_q, rdx_q, hit_tolerance));
		stat.below     = inrange_q && (sp_q < rdx_q);
		stat.sp_lo     = sp_lo_q;
		stat.sp_hi     = sp_hi_q;
	end

	// segment operands
	logic signed [plin_pkg::DW-1:0] dx, dy, den;
	always_comb begin
		dx  = {sp_q[plin_pkg::W-1], sp_q} - {xa_q[plin_pkg::W-1], xa_q};
		dy  = {rdy_q[plin_pkg::W-1], rdy_q} - {ya_q[plin_pkg::W-1], ya_q};
		den = {rdx_q[plin_pkg::W-1], rdx_q} - {xa_q[plin_pkg::W-1], xa_q};
	end

	// divider step
	logic [plin_pkg::DW:0] rs;
	logic ge;
	always_comb begin
		rs = {rem_q[plin_pkg::DW-1:0], acc_q[plin_pkg::PW-1]};
		ge = rs >= {1'b0, den_q};
	end

	// quotient clamp, signed sum and saturation
	logic [plin_pkg::QSAT_W-1:0] qc;
	logic signed [plin_pkg::SUM_W-1:0] ysum;
	logic signed [plin_pkg::W-1:0] sat;
	localparam logic [plin_pkg::QSAT_W-1:0] QSAT = {1'b1, {(plin_pkg::QSAT_W-1){1'b0}}};
	localparam logic signed [plin_pkg::SUM_W-1:0] SMAX =
		plin_pkg::SUM_W'({1'b0, {(plin_pkg::W-1){1'b1}}});
	localparam logic signed [plin_pkg::SUM_W-1:0] SMIN =
		{{(plin_pkg::SUM_W-plin_pkg::W+1){1'b1}}, {(plin_pkg::W-1){1'b0}}};
	always_comb begin
		qc = (acc_q > plin_pkg::PW'(QSAT)) ? QSAT : acc_q[plin_pkg::QSAT_W-1:0];
		if (neg_q) begin
			ysum = plin_pkg::SUM_W'(ya_q) - $signed({1'b0, qc});
		end else begin
			ysum = plin_pkg::SUM_W'(ya_q) + $signed({1'b0, qc});
		end
		if (ysum > SMAX) begin
			sat = {1'b0, {(plin_pkg::W-1){1'b1}}};
		end else if (ysum < SMIN) begin
			sat = {1'b1, {(plin_pkg::W-1){1'b0}}};
		end else begin
			sat = ysum[plin_pkg::W-1:0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			plin_pkg::OP_QUERY: begin
				sp_q <= setpoint;
			end
			plin_pkg::OP_CAP0: begin
				x0_q   <= rdx_q;
				y0_q   <= rdy_q;
				hit0_q <= near(sp_q, rdx_q, hit_tolerance);
			end
			plin_pkg::OP_CAPL: begin
				inrange_q <= (sp_q >= x0_q) && (sp_q <= rdx_q);
				sp_lo_q   <= sp_q < x0_q;
				sp_hi_q   <= sp_q > rdx_q;
				prev_q    <= x0_q;
			end
			plin_pkg::OP_EVAL: begin
				prev_q <= rdx_q;
				if (stat.order_err) begin
					value_q  <= '0;
					status_q <= plin_pkg::STAT_ORDER;
				end else if (stat.hit) begin
					value_q  <= hit_lo ? y0_q : rdy_q;
					status_q <= plin_pkg::STAT_OK;
				end
			end
			plin_pkg::OP_CAPA: begin
				xa_q <= rdx_q;
				ya_q <= rdy_q;
			end
			plin_pkg::OP_CAPB: begin
				ma_q  <= dx[plin_pkg::DW-1] ? (~dx + plin_pkg::DW'(1)) : dx;
				mb_q  <= dy[plin_pkg::DW-1] ? (~dy + plin_pkg::DW'(1)) : dy;
				neg_q <= dx[plin_pkg::DW-1] ^ dy[plin_pkg::DW-1];
				den_q <= den;
				acc_q <= '0;
				rem_q <= '0;
			end
			plin_pkg::OP_MUL: begin
				acc_q <= {acc_q[plin_pkg::PW-2:0], 1'b0}
					+ (mb_q[plin_pkg::DW-1] ? plin_pkg::PW'(ma_q) : '0);
				mb_q  <= {mb_q[plin_pkg::DW-2:0], 1'b0};
			end
			plin_pkg::OP_DIV: begin
				rem_q <= ge ? (rs - {1'b0, den_q}) : rs;
				acc_q <= {acc_q[plin_pkg::PW-2:0], ge};
			end
			plin_pkg::OP_FIN: begin
				value_q  <= sat;
				status_q <= plin_pkg::STAT_OK;
			end
			default: begin
			end
		endcase
	end

	assign value  = value_q;
	assign status = status_q;

endmodule

[rtl/plin_ctrl.sv]
// plin_ctrl: sequencer of the interpolator, issues datapath commands and
// table addresses and raises the result strobe. Depends on plin_pkg.
module plin_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            kind,
	input  logic [plin_pkg::CNT_CFG_W-1:0]  point_count,
	input  plin_pkg::stat_t                 stat,
	output plin_pkg::cmd_t                  cmd,
	output logic                            busy,
	output logic                            strobe
);

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_CAP0 = 11'b000_0000_0010,
		S_CAPL = 11'b000_0000_0100,
		S_SCRD = 11'b000_0000_1000,
		S_SCEV = 11'b000_0001_0000,
		S_RDA  = 11'b000_0010_0000,
		S_RDB  = 11'b000_0100_0000,
		S_CAPB = 11'b000_1000_0000,
		S_MUL  = 11'b001_0000_0000,
		S_DIV  = 11'b010_0000_0000,
		S_FIN  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic [plin_pkg::AW-1:0] idx_q, idx_d, seg_q, seg_d;
	logic [plin_pkg::STEP_W-1:0] cnt_q, cnt_d;
	logic strobe_q, strobe_d;

	// index of the last breakpoint in use, count clamped to the table
	logic [plin_pkg::AW-1:0] last;
	logic [plin_pkg::CNT_CFG_W-1:0] last_w;
	always_comb begin
		last_w = point_count - plin_pkg::CNT_CFG_W'(1);
		if (point_count < plin_pkg::CNT_CFG_W'(2)) begin
			last = plin_pkg::AW'(1);
		end else if (point_count > plin_pkg::CNT_CFG_W'(plin_pkg::DEPTH)) begin
			last = plin_pkg::AW'(plin_pkg::DEPTH - 1);
		end else begin
			last = last_w[plin_pkg::AW-1:0];
		end
	end

	// segment chosen after the scan
	logic [plin_pkg::AW-1:0] segf;
	always_comb begin
		if (stat.sp_lo) begin
			segf = plin_pkg::AW'(1);
		end else if (stat.sp_hi || seg_q == '0) begin
			segf = last;
		end else begin
			segf = seg_q;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		seg_d     = seg_q;
		cnt_d     = cnt_q;
		strobe_d  = 1'b0;
		cmd.op    = plin_pkg::OP_NONE;
		cmd.addr  = '0;
		cmd.first = idx_q == plin_pkg::AW'(1);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (kind == plin_pkg::KIND_LOAD) begin
						cmd.op = plin_pkg::OP_LOAD;
					end else begin
						cmd.op  = plin_pkg::OP_QUERY;
						idx_d   = plin_pkg::AW'(1);
						seg_d   = '0;
						state_d = S_CAP0;
					end
				end
			end
			S_CAP0: begin
				cmd.op   = plin_pkg::OP_CAP0;
				cmd.addr = last;
				state_d  = S_CAPL;
			end
			S_CAPL: begin
				cmd.op   = plin_pkg::OP_CAPL;
				cmd.addr = plin_pkg::AW'(1);
				state_d  = S_SCEV;
			end
			S_SCRD: begin
				cmd.addr = idx_q;
				state_d  = S_SCEV;
			end
			S_SCEV: begin
				cmd.op = plin_pkg::OP_EVAL;
				if (stat.order_err || stat.hit) begin
					strobe_d = 1'b1;
					state_d  = S_IDLE;
				end else begin
					if (seg_q == '0 && stat.below) begin
						seg_d = idx_q;
					end
					if (idx_q == last) begin
						state_d = S_RDA;
					end else begin
						idx_d   = idx_q + plin_pkg::AW'(1);
						state_d = S_SCRD;
					end
				end
			end
			S_RDA: begin
				cmd.addr = segf - plin_pkg::AW'(1);
				seg_d    = segf;
				state_d  = S_RDB;
			end
			S_RDB: begin
				cmd.op   = plin_pkg::OP_CAPA;
				cmd.addr = seg_q;
				state_d  = S_CAPB;
			end
			S_CAPB: begin
				cmd.op  = plin_pkg::OP_CAPB;
				cnt_d   = '0;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.op = plin_pkg::OP_MUL;
				if (cnt_q == plin_pkg::STEP_W'(plin_pkg::MUL_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = S_DIV;
				end else begin
					cnt_d = cnt_q + plin_pkg::STEP_W'(1);
				end
			end
			S_DIV: begin
				cmd.op = plin_pkg::OP_DIV;
				if (cnt_q == plin_pkg::STEP_W'(plin_pkg::DIV_STEPS - 1)) begin
					state_d = S_FIN;
				end else begin
					cnt_d = cnt_q + plin_pkg::STEP_W'(1);
				end
			end
			S_FIN: begin
				cmd.op   = plin_pkg::OP_FIN;
				strobe_d = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			seg_q    <= '0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			seg_q    <= seg_d;
			cnt_q    <= cnt_d;
			strobe_q <= strobe_d;
		end
	end

	assign busy   = state_q != S_IDLE;
	assign strobe = strobe_q;

endmodule

[rtl/piecewise_linear_interpolator_top.sv]
// piecewise_linear_interpolator_top: APB registers, controller and datapath.
// Depends on plin_pkg, plin_ctrl and plin_dp.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  input    | start & !busy          | kind, point_index, point_x, point_y, setpoint
//  result   | strobe, one cycle      | value, status
//  config   | psel & penable & pwrite| paddr, pwdata (prdata on reads)
//
// a load beat gives no result; busy stays low
// a query beat scans the breakpoints in use on the single table read port, then runs
// 33 shift-add multiplier steps and 66 restoring divider steps; hits and order
// errors end early
// arst_n clears the controller and the registers; the table holds no reset
// results cannot be stalled: the strobe beat is taken in the cycle it is shown
module piecewise_linear_interpolator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              kind,
	input  logic [plin_pkg::AW-1:0]           point_index,
	input  logic signed [plin_pkg::W-1:0]     point_x,
	input  logic signed [plin_pkg::W-1:0]     point_y,
	input  logic signed [plin_pkg::W-1:0]     setpoint,
	output logic                              strobe,
	output logic signed [plin_pkg::W-1:0]     value,
	output logic                              status,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [plin_pkg::ADDR_W-1:0]       paddr,
	input  logic [plin_pkg::DATA_W-1:0]       pwdata,
	output logic [plin_pkg::DATA_W-1:0]       prdata,
	output logic                              pready
);

	logic [plin_pkg::CNT_CFG_W-1:0] point_count_q;
	logic [plin_pkg::TOL_W-1:0]     hit_tol_q;
	plin_pkg::cmd_t  cmd;
	plin_pkg::stat_t stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= plin_pkg::CNT_CFG_W'(2);
			hit_tol_q     <= plin_pkg::TOL_W'(1);
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				plin_pkg::REG_POINT_COUNT: point_count_q <= pwdata[plin_pkg::CNT_CFG_W-1:0];
				default:                   hit_tol_q     <= pwdata[plin_pkg::TOL_W-1:0];
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[2])
			plin_pkg::REG_POINT_COUNT: prdata = plin_pkg::DATA_W'(point_count_q);
			default:                   prdata = plin_pkg::DATA_W'(hit_tol_q);
		endcase
	end

	assign pready = 1'b1;

	plin_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.kind        (kind),
		.point_count (point_count_q),
		.stat        (stat),
		.cmd         (cmd),
		.busy        (busy),
		.strobe      (strobe)
	);

	plin_dp u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.point_index   (point_index),
		.point_x       (point_x),
		.point_y       (point_y),
		.setpoint      (setpoint),
		.hit_tolerance (hit_tol_q),
		.stat          (stat),
		.value         (value),
		.status        (status)
	);

	// a result beat arrives only after the query has released the controller
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("result strobe while busy");

	// an order error carries a zero value
	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == plin_pkg::STAT_ORDER) |-> (value == '0))
		else $error("order error with nonzero value");

	// a load beat keeps the block free, a query beat occupies it
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == plin_pkg::KIND_LOAD) |=> !busy)
		else $error("load made the block busy");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == plin_pkg::KIND_QUERY) |=> (busy && !strobe))
		else $error("query not started");

endmodule
